// ----- rtl/core/se2em_pkg.sv -----
package se2em_pkg;

	localparam int unsigned INT_FRAC     = 28;
	localparam int unsigned SERIES_TERMS = 11;
	localparam logic [63:0] PI_Q61       = 64'h6487_ED51_10B4_611A;
	localparam logic signed [31:0] ONE_Q = 32'sh1000_0000;

	// everything an item needs besides the two series values
	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic [29:0]        t;
		logic [31:0]        u;
		logic               neg;
		logic               clamped;
		logic               near_zero;
	} side_t;

	// divisor of one horner step, before the q.28 scaling
	function automatic int unsigned div_const(input int unsigned k, input int unsigned first);
		return (2 * k + first) * (2 * k + first + 1);
	endfunction

	// round to nearest, ties away from zero
	function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
		input int unsigned sh);
		logic [63:0] m;
		logic [63:0] half;
		half = 64'd1 << (sh - 1);
		m = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
		m = (m + half) >> sh;
		return v[63] ? $signed(64'd0 - m) : $signed(m);
	endfunction

endpackage

// ----- rtl/core/se2_exponential_map_unit.sv -----
// se2 exponential map, fully pipelined
// items pass stage 1, stage 2, the horner chains and the tail stages before done
// throughput: one transaction per cycle; busy is low except during and just after reset
// the two horner series take 3 stages per term (multiply, reciprocal multiply, correct)
// reset clears the valid chain and sets small_angle_limit to 0; results cannot be stalled
module se2_exponential_map_unit #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int TRIG_FRAC_BITS  = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] rho_x,
	input  logic signed [31:0] rho_y,
	input  logic signed [15:0] angle,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	output logic               done,
	output logic signed [15:0] cos_out,
	output logic signed [15:0] sin_out,
	output logic signed [31:0] trans_x,
	output logic signed [31:0] trans_y,
	output logic               angle_clamped
);
	import se2em_pkg::*;

	localparam int NSTEP = SERIES_TERMS;
	localparam int HLEN  = 3 * NSTEP;
	localparam int LAT   = HLEN + 9;
	localparam logic [63:0] PI_A64 =
		(PI_Q61 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
	localparam int unsigned TSH_L = (TRIG_FRAC_BITS > INT_FRAC) ? TRIG_FRAC_BITS - INT_FRAC : 0;
	localparam int unsigned TSH_R = (TRIG_FRAC_BITS < INT_FRAC) ? INT_FRAC - TRIG_FRAC_BITS : 0;

	function automatic logic signed [15:0] to_trig(input logic signed [31:0] v);
		logic signed [63:0] r;
		r = 64'(v);
		if (TSH_L != 0)
			r = r <<< TSH_L;
		else if (TSH_R != 0)
			r = round_shift(r, TSH_R);
		if (r > 64'sd32767)
			return 16'sh7fff;
		if (r < -64'sd32768)
			return 16'sh8000;
		return r[15:0];
	endfunction

	function automatic logic signed [31:0] sat_trans(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = round_shift(v, INT_FRAC);
		if (r > 64'sd2147483647)
			return 32'sh7fff_ffff;
		if (r < -64'sd2147483648)
			return 32'sh8000_0000;
		return r[31:0];
	endfunction

	logic       busy_q;
	logic [7:0] limit_q;

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			limit_q <= '0;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				limit_q <= cfg_data;
		end
	end

	// stage 1: magnitude and clamp
	logic        neg_in;
	logic [16:0] mag_in;
	logic        clamp_in;
	assign neg_in   = angle[15];
	assign mag_in   = neg_in ? (17'd0 - {angle[15], angle}) : {1'b0, angle};
	assign clamp_in = {7'd0, mag_in} > PI_A64[23:0];

	logic               vld_s1;
	logic [16:0]        a_s1;
	logic               neg_s1, clamped_s1;
	logic signed [31:0] rx_s1, ry_s1;

	always_ff @(posedge clk) begin
		a_s1       <= clamp_in ? PI_A64[16:0] : mag_in;
		neg_s1     <= neg_in;
		clamped_s1 <= clamp_in;
		rx_s1      <= rho_x;
		ry_s1      <= rho_y;
	end

	// stage 2: t and u = t^2
	logic [47:0] t_wide;
	logic [29:0] t_in;
	logic [59:0] tt;
	assign t_wide = 48'(a_s1) << (INT_FRAC - ANGLE_FRAC_BITS);
	assign t_in   = t_wide[29:0];
	assign tt     = 60'(t_in) * 60'(t_in);

	logic  vld_s2;
	side_t side_s2;

	always_ff @(posedge clk) begin
		side_s2.rx        <= rx_s1;
		side_s2.ry        <= ry_s1;
		side_s2.t         <= t_in;
		side_s2.u         <= tt[59:28];
		side_s2.neg       <= neg_s1;
		side_s2.clamped   <= clamped_s1;
		side_s2.near_zero <= a_s1 <= {9'd0, limit_q};
	end

	// horner pipelines for sin(t)/t and (1-cos t)/t^2
	logic [31:0]        x_sh   [2][NSTEP];
	logic [31:0]        xb_sh  [2][NSTEP];
	logic [29:0]        q0_sh  [2][NSTEP];
	logic signed [31:0] acc_sh [2][NSTEP];
	side_t              side_sh [HLEN];
	logic               vld_sh  [HLEN];

	for (genvar sr = 0; sr < 2; sr++) begin : g_series
		for (genvar j = 0; j < NSTEP; j++) begin : g_step
			localparam logic [63:0] DIV   = 64'(div_const(NSTEP - j, sr));
			localparam logic [63:0] RECIP = (64'd1 << 32) / DIV;
			logic [31:0] u_in;
			logic [28:0] acc_in;
			logic [60:0] prod;
			logic [61:0] qprod;
			logic [41:0] qd;
			logic [31:0] rem;
			logic [30:0] q;

			if (j == 0) begin : g_first
				assign u_in   = side_s2.u;
				assign acc_in = ONE_Q[28:0];
			end else begin : g_next
				assign u_in   = side_sh[3 * j - 1].u;
				assign acc_in = acc_sh[sr][j - 1][28:0];
			end

			assign prod  = 61'(u_in) * 61'(acc_in);
			assign qprod = 62'(x_sh[sr][j]) * 62'(RECIP[29:0]);
			assign qd    = 42'(q0_sh[sr][j]) * 42'(DIV[9:0]);
			assign rem   = xb_sh[sr][j] - qd[31:0];
			// reciprocal estimate is low by at most one
			assign q     = (rem >= DIV[31:0]) ? 31'(q0_sh[sr][j]) + 31'd1
				: 31'(q0_sh[sr][j]);

			always_ff @(posedge clk) begin
				x_sh[sr][j]   <= prod[59:28];
				xb_sh[sr][j]  <= x_sh[sr][j];
				q0_sh[sr][j]  <= qprod[61:32];
				acc_sh[sr][j] <= ONE_Q - $signed(32'(q));
			end
		end
	end

	always_ff @(posedge clk) begin
		side_sh[0] <= side_s2;
		for (int i = 1; i < HLEN; i++)
			side_sh[i] <= side_sh[i - 1];
	end

	// tail stages
	logic               vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	side_t              side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic signed [63:0] pa_s3, pg_s3;
	logic signed [31:0] a_s3;
	logic signed [31:0] a_s4, b_s4, sin_s4;
	logic signed [63:0] pb_s5;
	logic signed [31:0] a_s5, b_s5, sin_s5;
	logic signed [31:0] a_s6, b_s6, sin_s6, cos_s6;
	logic signed [63:0] p0_s7, p1_s7, p2_s7, p3_s7;
	logic signed [31:0] sin_s7, cos_s7;
	logic signed [63:0] sx_s8, sy_s8;
	logic signed [15:0] sin_s8, cos_s8;

	logic signed [63:0] t_s;
	logic signed [63:0] t5_s;
	logic signed [63:0] b_rnd, s_rnd, c_rnd;
	assign t_s   = 64'($signed({2'b00, side_sh[HLEN - 1].t}));
	assign t5_s  = 64'($signed({2'b00, side_s4.t}));
	assign b_rnd = round_shift(pg_s3, INT_FRAC + 1);
	assign s_rnd = round_shift(pa_s3, INT_FRAC);
	assign c_rnd = round_shift(pb_s5, INT_FRAC);

	always_ff @(posedge clk) begin
		side_s3 <= side_sh[HLEN - 1];
		a_s3    <= acc_sh[0][NSTEP - 1];
		pa_s3   <= t_s * 64'(acc_sh[0][NSTEP - 1]);
		pg_s3   <= t_s * 64'(acc_sh[1][NSTEP - 1]);

		side_s4 <= side_s3;
		a_s4    <= a_s3;
		b_s4    <= b_rnd[31:0];
		sin_s4  <= s_rnd[31:0];

		side_s5 <= side_s4;
		a_s5    <= a_s4;
		b_s5    <= b_s4;
		sin_s5  <= sin_s4;
		pb_s5   <= t5_s * 64'(b_s4);

		side_s6 <= side_s5;
		cos_s6  <= ONE_Q - c_rnd[31:0];
		sin_s6  <= side_s5.neg ? -sin_s5 : sin_s5;
		a_s6    <= side_s5.near_zero ? ONE_Q : a_s5;
		b_s6    <= side_s5.near_zero ? 32'sd0 : (side_s5.neg ? -b_s5 : b_s5);

		side_s7 <= side_s6;
		sin_s7  <= sin_s6;
		cos_s7  <= cos_s6;
		p0_s7   <= 64'(a_s6) * 64'(side_s6.rx);
		p1_s7   <= 64'(b_s6) * 64'(side_s6.ry);
		p2_s7   <= 64'(b_s6) * 64'(side_s6.rx);
		p3_s7   <= 64'(a_s6) * 64'(side_s6.ry);

		side_s8 <= side_s7;
		sx_s8   <= p0_s7 - p1_s7;
		sy_s8   <= p2_s7 + p3_s7;
		sin_s8  <= to_trig(sin_s7);
		cos_s8  <= to_trig(cos_s7);

		cos_out       <= cos_s8;
		sin_out       <= sin_s8;
		trans_x       <= sat_trans(sx_s8);
		trans_y       <= sat_trans(sy_s8);
		angle_clamped <= side_s8.clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int i = 0; i < HLEN; i++)
				vld_sh[i] <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1    <= start && !busy_q;
			vld_s2    <= vld_s1;
			vld_sh[0] <= vld_s2;
			for (int i = 1; i < HLEN; i++)
				vld_sh[i] <= vld_sh[i - 1];
			vld_s3 <= vld_sh[HLEN - 1];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			done   <= vld_s8;
		end
	end

	// every accepted transaction comes out with done once through the pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction did not complete on time");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ({7'd0, a_s1} <= PI_A64[23:0]))
		else $error("clamped angle above pi");

	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && side_s6.near_zero) |-> (b_s6 == 32'sd0 && a_s6 == ONE_Q))
		else $error("small angle did not force identity");

	// inner horner accumulators stay in [0, 1], the multiplier relies on it
	for (genvar j = 0; j < NSTEP - 1; j++) begin : g_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			vld_sh[3 * j + 2] |-> (!acc_sh[0][j][31] && !acc_sh[1][j][31]
				&& acc_sh[0][j] <= ONE_Q && acc_sh[1][j] <= ONE_Q))
			else $error("horner accumulator out of range");
	end

endmodule

// ----- bench/se2_exponential_map_unit_test.sv -----
`timescale 1ns / 1ps

module se2_exponential_map_unit_test;
	import se2em_pkg::*;

	localparam int ANGLE_FB   = 13;
	localparam int TRIG_FB    = 14;
	localparam int LATENCY    = 42;
	localparam int CYCLE_MAX  = 400000;

	typedef struct {
		logic signed [15:0] cos_v;
		logic signed [15:0] sin_v;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic               clamped;
	} pose_t;

	class pose_scoreboard;
		pose_t      pending[$];
		logic [7:0] small_limit;
		int         errors;

		function new();
			small_limit = 8'd0;
			errors = 0;
		endfunction

		// round to nearest, ties away from zero
		function longint rnd(longint v, int sh);
			longint m;
			m = (v < 0) ? -v : v;
			m = (m + (longint'(1) << (sh - 1))) >>> sh;
			return (v < 0) ? -m : m;
		endfunction

		function longint sat(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function longint series(longint u, longint first);
			longint acc;
			longint d;
			acc = longint'(1) << INT_FRAC;
			for (longint k = SERIES_TERMS; k >= 1; k--) begin
				d = (2 * k + first) * (2 * k + first + 1);
				acc = (longint'(1) << INT_FRAC) - (u * acc) / (d << INT_FRAC);
			end
			return acc;
		endfunction

		function longint trig_q(longint v);
			longint r;
			if (TRIG_FB > INT_FRAC)
				r = v * (longint'(1) << (TRIG_FB - INT_FRAC));
			else if (TRIG_FB == INT_FRAC)
				r = v;
			else
				r = rnd(v, INT_FRAC - TRIG_FB);
			return sat(r, -32768, 32767);
		endfunction

		// notes an accepted transaction and queues the pose it must produce
		function void note_twist(logic signed [31:0] rx, logic signed [31:0] ry,
			logic signed [15:0] ang);
			logic [63:0] pi_u;
			longint pi_a, a, t, u, ca, cg, cb, s, c, one;
			bit neg;
			pose_t p;
			one = longint'(1) << INT_FRAC;
			pi_u = (PI_Q61 + (64'd1 << (60 - ANGLE_FB))) >> (61 - ANGLE_FB);
			pi_a = longint'(pi_u);
			neg = ang < 0;
			a = neg ? -longint'(ang) : longint'(ang);
			p.clamped = 1'b0;
			if (a > pi_a) begin
				a = pi_a;
				p.clamped = 1'b1;
			end
			t = a << (INT_FRAC - ANGLE_FB);
			u = (t * t) >>> INT_FRAC;
			ca = series(u, 0);
			cg = series(u, 1);
			cb = rnd(t * cg, INT_FRAC + 1);
			s = rnd(t * ca, INT_FRAC);
			c = one - rnd(t * cb, INT_FRAC);
			if (neg) begin
				s = -s;
				cb = -cb;
			end
			if (a <= longint'(small_limit)) begin
				ca = one;
				cb = 0;
			end
			p.cos_v = 16'(trig_q(c));
			p.sin_v = 16'(trig_q(s));
			p.tx = 32'(sat(rnd(ca * rx - cb * ry, INT_FRAC),
				-64'sd2147483648, 64'sd2147483647));
			p.ty = 32'(sat(rnd(cb * rx + ca * ry, INT_FRAC),
				-64'sd2147483648, 64'sd2147483647));
			pending.push_back(p);
		endfunction

		function void check_pose(pose_t got);
			pose_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t unexpected result cos=%0d sin=%0d tx=%0d ty=%0d",
						$realtime, got.cos_v, got.sin_v, got.tx, got.ty);
				return;
			end
			e = pending.pop_front();
			if (got.cos_v !== e.cos_v || got.sin_v !== e.sin_v || got.tx !== e.tx ||
				got.ty !== e.ty || got.clamped !== e.clamped) begin
				errors++;
				if (errors <= 10)
					$display({"%0t mismatch exp cos=%0d sin=%0d tx=%0d ty=%0d clamp=%0b",
						" / got cos=%0d sin=%0d tx=%0d ty=%0d clamp=%0b"},
						$realtime, e.cos_v, e.sin_v, e.tx, e.ty, e.clamped,
						got.cos_v, got.sin_v, got.tx, got.ty, got.clamped);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] rho_x;
	logic signed [31:0] rho_y;
	logic signed [15:0] angle;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         cfg_data;
	logic               done;
	logic signed [15:0] cos_out;
	logic signed [15:0] sin_out;
	logic signed [31:0] trans_x;
	logic signed [31:0] trans_y;
	logic               angle_clamped;

	pose_scoreboard sb = new();
	int             cycles = 0;
	bit             no_gaps;

	se2_exponential_map_unit #(
		.ANGLE_FRAC_BITS(ANGLE_FB),
		.TRIG_FRAC_BITS (TRIG_FB)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.rho_x        (rho_x),
		.rho_y        (rho_y),
		.angle        (angle),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.cos_out      (cos_out),
		.sin_out      (sin_out),
		.trans_x      (trans_x),
		.trans_y      (trans_y),
		.angle_clamped(angle_clamped)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		pose_t got;
		if (arst_n && done) begin
			got.cos_v = cos_out;
			got.sin_v = sin_out;
			got.tx = trans_x;
			got.ty = trans_y;
			got.clamped = angle_clamped;
			sb.check_pose(got);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic idle_gap();
		int g;
		if (no_gaps || $urandom_range(0, 2) == 0)
			g = 0;
		else if ($urandom_range(0, 9) == 0)
			g = $urandom_range(6, 40);
		else
			g = $urandom_range(1, 3);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_twist(logic signed [31:0] rx, logic signed [31:0] ry,
		logic signed [15:0] ang);
		start <= 1'b1;
		rho_x <= rx;
		rho_y <= ry;
		angle <= ang;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_twist(rx, ry, ang);
		idle_gap();
	endtask

	task automatic write_limit(logic [7:0] v);
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.small_limit = v;
		cfg_valid <= 1'b0;
		repeat ($urandom_range(1, 4)) @(posedge clk);
	endtask

	task automatic random_twists(int n);
		logic signed [31:0] rx, ry;
		logic signed [15:0] ang;
		int sel;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 7);
			case (sel)
				0, 1: ang = 16'($urandom_range(0, 300));
				2: ang = 16'(25736 + $urandom_range(0, 7031));
				default: ang = 16'($urandom);
			endcase
			if ($urandom_range(0, 1) == 1 && sel < 3)
				ang = -ang;
			sel = $urandom_range(0, 5);
			case (sel)
				0: begin
					rx = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
					ry = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
				end
				1, 2: begin
					rx = 32'($signed(17'($urandom)));
					ry = 32'($signed(17'($urandom)));
				end
				default: begin
					rx = $urandom;
					ry = $urandom;
				end
			endcase
			send_twist(rx, ry, ang);
		end
	endtask

	initial begin
		logic signed [15:0] dir_angles[16];
		arst_n = 1'b0;
		start = 1'b0;
		rho_x = '0;
		rho_y = '0;
		angle = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		no_gaps = 1'b0;
		dir_angles = '{16'sd0, 16'sd1, -16'sd1, 16'sd25736, -16'sd25736, 16'sd25737,
			-16'sd25737, 16'sd32767, -16'sd32768, 16'sd255, 16'sd256, -16'sd256,
			16'sd12868, -16'sd6434, 16'sd19302, 16'sd100};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: only a zero angle is taken as small
		foreach (dir_angles[i])
			send_twist(32'sh0001_0000, -32'sh0002_8000, dir_angles[i]);
		send_twist(32'sh7fff_ffff, 32'sh8000_0000, 16'sd12868);
		send_twist(32'sh8000_0000, 32'sh8000_0000, -16'sd25736);
		send_twist(32'sh7fff_ffff, 32'sh7fff_ffff, 16'sd0);
		random_twists(200);

		write_limit(8'd255);
		foreach (dir_angles[i])
			send_twist(32'sh8000_0000, 32'sh7fff_ffff, dir_angles[i]);
		random_twists(200);

		write_limit(8'd17);
		send_twist(32'sh0003_0000, 32'sh0001_0000, 16'sd17);
		send_twist(32'sh0003_0000, 32'sh0001_0000, -16'sd18);
		random_twists(200);

		write_limit(8'($urandom));
		random_twists(150);

		write_limit(8'd0);
		random_twists(100);

		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
